/* src/random_draw_without_replacement_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the draw-without-replacement block
// Shared property forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef RANDOM_DRAW_WITHOUT_REPLACEMENT_ASSERT_SVH
`define RANDOM_DRAW_WITHOUT_REPLACEMENT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RDWR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rdwr assertion failed");

// next-cycle implication, held off during reset
`define RDWR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rdwr assertion failed");

// next-cycle implication, also checked across reset
`define RDWR_ASSERT_NXT_ANY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rdwr assertion failed");

`endif

/* src/rdwr_pkg.sv */
// ----------------------------------------------------------------------------
// rdwr_pkg
// Types and fixed widths for the draw-without-replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdwr_pkg;

   localparam int RANDOM_W = 8;
   localparam int INDEX_W  = 7;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_MARK
   } rdwr_state_type;

endpackage

/* src/random_draw_without_replacement.sv */
// ----------------------------------------------------------------------------
// random_draw_without_replacement
// Shuffle bag: each request word draws one unused pool entry, chosen by a
// random byte reduced modulo the unused count, and refills the pool when it
// runs empty.
//
//   channel | direction | words
//   req_    | in        | random_byte
//   rsp_    | out       | picked_index, pool_refilled
//
// A draw first reduces the byte by restoring remainder (one bit per cycle
// through a shared compare/subtract), then scans the marks in the mark
// memory (single read port, registered), at most ENTRIES of them, then
// registers the response word and, unless the pool ran empty, marks the pick.
// After reset, and after a draw that empties the pool, the mark memory is
// swept clear at one entry per cycle; req_ready is low then.
// A finished word waits in the output register; a stalled rsp_ holds only
// the final mark step of the next draw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module random_draw_without_replacement #(
   parameter int ENTRIES = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rdwr_pkg::RANDOM_W-1:0]     req_random_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rdwr_pkg::INDEX_W-1:0]      rsp_picked_index,
   output logic                              rsp_pool_refilled
);
   import rdwr_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL     = CW'(ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [IW:0]   PTR_END  = (IW + 1)'(ENTRIES);

   rdwr_state_type state_ff, state_in;
   logic [IW:0]           ptr_ff, ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [RANDOM_W-1:0]   rnd_ff, rnd_in;
   logic [2:0]            step_ff, step_in;
   logic [IW-1:0]         pick_ff, pick_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IW-1:0]         rd_tag_ff, rd_tag_in;
   logic                  mark_rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                  rsp_refill_ff, rsp_refill_in;

   logic                  mark_mem [ENTRIES];
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   logic                  mem_wdata;
   logic [IW-1:0]         mem_raddr;

   logic [CW:0]           trial;
   logic [CW:0]           diff;
   logic                  trial_ge;
   logic [IW+INDEX_W-1:0] pick_ext;

   assign trial    = {rem_ff, rnd_ff[RANDOM_W-1]};
   assign diff     = trial - {1'b0, cnt_ff};
   assign trial_ge = trial >= {1'b0, cnt_ff};
   assign pick_ext = {{INDEX_W{1'b0}}, pick_ff};
   assign mem_raddr = ptr_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[mem_waddr] <= mem_wdata;
      end
      mark_rd_ff <= mark_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         cnt_ff       <= FULL;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      rnd_ff        <= rnd_in;
      step_ff       <= step_in;
      pick_ff       <= pick_in;
      rd_tag_ff     <= rd_tag_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_refill_ff <= rsp_refill_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      rnd_in        = rnd_ff;
      step_in       = step_ff;
      pick_in       = pick_ff;
      rd_vld_in     = 1'b0;
      rd_tag_in     = ptr_ff[IW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_refill_in = rsp_refill_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff[IW-1:0];
      mem_wdata     = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff[IW-1:0] == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rnd_in  = req_random_byte;
               rem_in  = '0;
               step_in = 3'd7;
               if (cnt_ff == '0 || cnt_ff > FULL) begin
                  cnt_in = FULL;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? diff[CW-1:0] : trial[CW-1:0];
            rnd_in  = {rnd_ff[RANDOM_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == 3'd0) begin
               ptr_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ptr_ff < PTR_END) begin
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               priority if (!mark_rd_ff && rem_ff == '0) begin
                  pick_in  = rd_tag_ff;
                  state_in = ST_MARK;
               end else if (rd_tag_ff == LAST_IDX) begin
                  pick_in  = LAST_IDX;
                  state_in = ST_MARK;
               end else if (!mark_rd_ff) begin
                  rem_in = rem_ff - 1'b1;
               end
            end
         end
         ST_MARK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = pick_ext[INDEX_W-1:0];
               rsp_refill_in = (cnt_ff == CW'(1));
               if (cnt_ff == CW'(1)) begin
                  cnt_in   = FULL;
                  ptr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = pick_ff;
                  mem_wdata = 1'b1;
                  cnt_in    = cnt_ff - 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_picked_index  = rsp_index_ff;
   assign rsp_pool_refilled = rsp_refill_ff;

endmodule

/* src/rdwr_checker.sv */
// ----------------------------------------------------------------------------
// rdwr_checker
// Port-level checks for the draw-without-replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_draw_without_replacement_assert.svh"

module rdwr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [rdwr_pkg::RANDOM_W-1:0] req_random_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rdwr_pkg::INDEX_W-1:0]  rsp_picked_index,
   input logic                          rsp_pool_refilled
);
   import rdwr_pkg::*;

   logic req_fire;
   logic rsp_fire;
   logic byte_seen;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign byte_seen = ^req_random_byte || !(^req_random_byte);

   `RDWR_ASSERT_NXT_ANY(a_clear_after_reset, reset, !req_ready)
   `RDWR_ASSERT_NXT(a_busy_after_accept, req_fire && byte_seen, !req_ready)
   `RDWR_ASSERT_IMP(a_no_word_soon, req_fire, ##2 !req_ready)
   `RDWR_ASSERT_NXT(a_hold_stalled_word, rsp_valid && !rsp_ready && !rsp_fire,
      rsp_valid && $stable(rsp_picked_index) && $stable(rsp_pool_refilled))

endmodule

bind random_draw_without_replacement rdwr_checker u_rdwr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_random_byte   (req_random_byte),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_picked_index  (rsp_picked_index),
   .rsp_pool_refilled (rsp_pool_refilled)
);
